// File: design/mtp_pkg.sv
// Shared constants for the musical transport phasor: field widths, register
// indexes, reset values and default parameter values. No dependencies.
`default_nettype none

package mtp_pkg;

  localparam int PHASE_BITS_DEF = 16;
  localparam int TIME_BITS_DEF  = 48;

  localparam int RAW_W    = 32;
  localparam int WRAP_W   = 16;
  localparam int COUNT_W  = 32;
  localparam int BEAT_W   = 32;
  localparam int PERIOD_W = 40;

  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_BEAT    = 2'd0;
  localparam reg_idx_t REG_BAR     = 2'd1;
  localparam reg_idx_t REG_PHRASE  = 2'd2;
  localparam reg_idx_t REG_SECTION = 2'd3;

  localparam logic [BEAT_W-1:0]   BEAT_RESET    = 32'd500000;
  localparam logic [PERIOD_W-1:0] BAR_RESET     = 40'd2000000;
  localparam logic [PERIOD_W-1:0] PHRASE_RESET  = 40'd8000000;
  localparam logic [PERIOD_W-1:0] SECTION_RESET = 40'd32000000;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_ORIGIN = 1'b1;

endpackage

`default_nettype wire

// File: design/mtp_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Has no package dependencies; a zero divisor is taken as one.
`default_nettype none

module mtp_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 40
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic [NUM_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           fits;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= (divisor == '0) ? DEN_W'(1) : divisor;
    end else if (run_r) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: design/mtp_timebase.sv
// Extends 32-bit counter samples to boot time by counting wraps and keeps the
// transport origin. Depends on mtp_pkg.
`default_nettype none

module mtp_timebase #(
  parameter int TIME_BITS = mtp_pkg::TIME_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       take,
  input  wire logic                       mode,
  input  wire logic [mtp_pkg::RAW_W-1:0]  raw,
  output logic [TIME_BITS-1:0]            boot_time,
  output logic [TIME_BITS-1:0]            transport_time
);

  logic [mtp_pkg::RAW_W-1:0]  prev_r;
  logic [mtp_pkg::WRAP_W-1:0] wrap_r;
  logic [mtp_pkg::WRAP_W-1:0] wrap_nxt;
  logic [TIME_BITS-1:0]       ext_r;
  logic [TIME_BITS-1:0]       ext_nxt;
  logic [TIME_BITS-1:0]       origin_r;
  logic [63:0]                wide;

  always_comb begin
    wrap_nxt = wrap_r;
    if (raw < prev_r && wrap_r != '1) begin
      wrap_nxt = wrap_r + mtp_pkg::WRAP_W'(1);
    end
    wide    = 64'({wrap_nxt, raw});
    ext_nxt = wide[TIME_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      wrap_r   <= '0;
      ext_r    <= '0;
      origin_r <= '0;
    end else if (take) begin
      if (mode == mtp_pkg::MODE_ORIGIN) begin
        origin_r <= ext_r;
      end else begin
        prev_r <= raw;
        wrap_r <= wrap_nxt;
        ext_r  <= ext_nxt;
      end
    end
  end

  assign boot_time      = ext_r;
  assign transport_time = ext_r - origin_r;

endmodule

`default_nettype wire

// File: design/musical_transport_phasor_unit.sv
// Top level of the musical transport phasor: handshakes, period registers and
// the sequencer that runs four divisions on one shared divider. Depends on
// mtp_pkg, mtp_timebase and mtp_div.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   in_mode, in_raw_micros
//   out_     output     out_valid / out_ready times, phases and counts
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each item runs the one-bit-per-cycle divider once per period.
// Reset is synchronous on rst_n and restores the period registers.
// The next item is taken while a finished result still waits on out_ready;
// a stalled result only holds the following item in its final state, ST_FIN.
// cfg_ready is always high.
`default_nettype none

module musical_transport_phasor_unit #(
  parameter int PHASE_BITS = mtp_pkg::PHASE_BITS_DEF,
  parameter int TIME_BITS  = mtp_pkg::TIME_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_mode,
  input  wire logic [mtp_pkg::RAW_W-1:0]       in_raw_micros,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [TIME_BITS-1:0]                 out_boot_time_us,
  output logic [TIME_BITS-1:0]                 out_transport_time_us,
  output logic [PHASE_BITS-1:0]                out_beat_phase,
  output logic [mtp_pkg::COUNT_W-1:0]          out_beat_count,
  output logic [PHASE_BITS-1:0]                out_bar_phase,
  output logic [mtp_pkg::COUNT_W-1:0]          out_bar_count,
  output logic [PHASE_BITS-1:0]                out_phrase_phase,
  output logic [PHASE_BITS-1:0]                out_section_phase,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mtp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mtp_pkg::PERIOD_W-1:0]    cfg_data
);

  localparam int NUM_W = TIME_BITS + PHASE_BITS;
  localparam int CW    = mtp_pkg::COUNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]                      state_r;
  logic [1:0]                      state_nxt;
  mtp_pkg::reg_idx_t               idx_r;
  logic [mtp_pkg::BEAT_W-1:0]      beat_len_r;
  logic [mtp_pkg::PERIOD_W-1:0]    bar_len_r;
  logic [mtp_pkg::PERIOD_W-1:0]    phrase_len_r;
  logic [mtp_pkg::PERIOD_W-1:0]    section_len_r;
  logic [mtp_pkg::PERIOD_W-1:0]    divisor;
  logic                            in_take;
  logic                            out_load;
  logic                            div_done;
  logic [NUM_W-1:0]                quotient;
  logic [TIME_BITS-1:0]            boot_time;
  logic [TIME_BITS-1:0]            transport_time;
  logic [PHASE_BITS-1:0]           beat_phase_r;
  logic [CW-1:0]                   beat_count_r;
  logic [PHASE_BITS-1:0]           bar_phase_r;
  logic [CW-1:0]                   bar_count_r;
  logic [PHASE_BITS-1:0]           phrase_phase_r;
  logic [PHASE_BITS-1:0]           section_phase_r;
  logic                            out_valid_r;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_len_r    <= mtp_pkg::BEAT_RESET;
      bar_len_r     <= mtp_pkg::BAR_RESET;
      phrase_len_r  <= mtp_pkg::PHRASE_RESET;
      section_len_r <= mtp_pkg::SECTION_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mtp_pkg::REG_BEAT:    beat_len_r    <= cfg_data[mtp_pkg::BEAT_W-1:0];
        mtp_pkg::REG_BAR:     bar_len_r     <= cfg_data;
        mtp_pkg::REG_PHRASE:  phrase_len_r  <= cfg_data;
        mtp_pkg::REG_SECTION: section_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mtp_timebase #(
    .TIME_BITS(TIME_BITS)
  ) u_timebase (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (in_take),
    .mode           (in_mode),
    .raw            (in_raw_micros),
    .boot_time      (boot_time),
    .transport_time (transport_time)
  );

  always_comb begin
    unique case (idx_r)
      mtp_pkg::REG_BEAT:    divisor = mtp_pkg::PERIOD_W'(beat_len_r);
      mtp_pkg::REG_BAR:     divisor = bar_len_r;
      mtp_pkg::REG_PHRASE:  divisor = phrase_len_r;
      mtp_pkg::REG_SECTION: divisor = section_len_r;
      default:              divisor = section_len_r;
    endcase
  end

  mtp_div #(
    .NUM_W(NUM_W),
    .DEN_W(mtp_pkg::PERIOD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_LOAD),
    .dividend ({transport_time, {PHASE_BITS{1'b0}}}),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = (idx_r == mtp_pkg::REG_SECTION) ? ST_FIN : ST_LOAD;
        end
      end
      ST_FIN: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= mtp_pkg::REG_BEAT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_take) begin
        idx_r <= mtp_pkg::REG_BEAT;
      end else if (state_r == ST_DIV && div_done && idx_r != mtp_pkg::REG_SECTION) begin
        idx_r <= idx_r + mtp_pkg::CFG_IDX_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV && div_done) begin
      unique case (idx_r)
        mtp_pkg::REG_BEAT: begin
          beat_phase_r <= quotient[PHASE_BITS-1:0];
          beat_count_r <= quotient[PHASE_BITS +: CW];
        end
        mtp_pkg::REG_BAR: begin
          bar_phase_r <= quotient[PHASE_BITS-1:0];
          bar_count_r <= quotient[PHASE_BITS +: CW];
        end
        mtp_pkg::REG_PHRASE:  phrase_phase_r  <= quotient[PHASE_BITS-1:0];
        mtp_pkg::REG_SECTION: section_phase_r <= quotient[PHASE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_boot_time_us      <= boot_time;
      out_transport_time_us <= transport_time;
      out_beat_phase        <= beat_phase_r;
      out_beat_count        <= beat_count_r;
      out_bar_phase         <= bar_phase_r;
      out_bar_count         <= bar_count_r;
      out_phrase_phase      <= phrase_phase_r;
      out_section_phase     <= section_phase_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
